// File: rtl/pim_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pim_pkg
// Shared field widths and register codes of the palette mip chain core.
// ---------------------------------------------------------------------------
package pim_pkg;

    localparam int PIX_W   = 8;
    localparam int LEVEL_W = 4;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;
    typedef logic               cfg_index_t;

    localparam cfg_index_t REG_BASE_WIDTH  = 1'b0;
    localparam cfg_index_t REG_BASE_HEIGHT = 1'b1;

    localparam cfg_data_t DIM_RESET = 13'd256;

endpackage

// File: rtl/pim_pixel_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pim_pixel_if
// Input channel: one base pixel palette index per item.
// ---------------------------------------------------------------------------
interface pim_pixel_if;
    logic          valid;
    logic          ready;
    pim_pkg::pix_t pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

// File: rtl/pim_result_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pim_result_if
// Output channel: one mip level pixel with its level and coordinates.
// ---------------------------------------------------------------------------
interface pim_result_if;
    logic            valid;
    logic            ready;
    pim_pkg::level_t level;
    pim_pkg::coord_t column;
    pim_pkg::coord_t row;
    pim_pkg::pix_t   value;
    logic            last_in_run;
    logic            chain_done;

    modport source (output valid, output level, output column, output row,
                    output value, output last_in_run, output chain_done,
                    input ready);
    modport sink   (input valid, input level, input column, input row,
                    input value, input last_in_run, input chain_done,
                    output ready);
endinterface

// File: rtl/palette_index_mode_mip_chain_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_index_mode_mip_chain_core
// Streaming 2x2 mode-filter mip chain builder for palette index images.
// ---------------------------------------------------------------------------
// Base pixels enter in raster order; each is returned as level 0 and walked
// up the chain one level per visit of a small sequencer, emitting a result
// for every level it reaches. An item is accepted in S_IDLE, then visits
// S_LEVEL once per level reached, via S_RD_A when the pair partner comes
// from the row store and via S_RD_A and S_RD_B for a full 2x2 block (both
// upper texels are read through the single row store port). Output stalls
// hold S_LEVEL; a new pixel waits for S_IDLE. No clearing pass after reset.
// ---------------------------------------------------------------------------
module palette_index_mode_mip_chain_core #(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_LEVELS = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  pim_pkg::cfg_index_t   cfg_index,
    input  pim_pkg::cfg_data_t    cfg_data,
    pim_pixel_if.sink             pixel,
    pim_result_if.source          result
);
    import pim_pkg::*;

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = $clog2(MAX_DIM);
    localparam int DEPTH = 2 * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int LVW   = $clog2(MAX_LEVELS);

    typedef enum logic [1:0] {S_IDLE, S_LEVEL, S_RD_A, S_RD_B} state_t;

    typedef logic [DW-1:0] dim_t;
    typedef logic [CW-1:0] pos_t;
    typedef logic [AW-1:0] addr_t;

    state_t            state_reg;
    cfg_data_t         cfg_w_reg;
    cfg_data_t         cfg_h_reg;
    pos_t              col_reg  [MAX_LEVELS];
    pos_t              row_reg  [MAX_LEVELS];
    pix_t              left_reg [MAX_LEVELS];
    logic [LVW-1:0]    lv_reg;
    dim_t              lw_reg;
    dim_t              lh_reg;
    addr_t             off_reg;
    pix_t              v_reg;
    pix_t              a0_reg;
    pos_t              x_reg;
    logic              pair_reg;
    logic              img_end_reg;

    logic              out_valid_reg;
    level_t            out_level_reg;
    coord_t            out_col_reg;
    coord_t            out_row_reg;
    pix_t              out_value_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    pos_t   x, y;
    dim_t   x_inc, y_inc, nw, nh;
    logic   x_last, y_last, stop, go;
    logic   wr_store, wr_left, rd_pair, use_left, rd_quad, last, done_now;
    logic   ram_we;
    addr_t  ram_addr;
    pix_t   ram_rdata;

    function automatic dim_t clamp_dim(input cfg_data_t d);
        if (d == '0)
            return dim_t'(1);
        else if (32'(d) > MAX_DIM)
            return dim_t'(MAX_DIM);
        else
            return dim_t'(d);
    endfunction

    // most common of four, ties to the earliest
    function automatic pix_t mode4(input pix_t a, input pix_t b,
                                   input pix_t c, input pix_t d);
        pix_t       t [4];
        logic [2:0] cnt;
        logic [2:0] best_cnt;
        pix_t       best;
        t = '{a, b, c, d};
        best = a;
        best_cnt = '0;
        for (int i = 0; i < 4; i++)
        begin
            cnt = '0;
            for (int j = 0; j < 4; j++)
            begin
                cnt = cnt + 3'((t[j] == t[i]) ? 1 : 0);
            end
            if (cnt > best_cnt)
            begin
                best_cnt = cnt;
                best = t[i];
            end
        end
        return best;
    endfunction

    always_comb
    begin
        x      = col_reg[lv_reg];
        y      = row_reg[lv_reg];
        x_inc  = dim_t'(x) + dim_t'(1);
        y_inc  = dim_t'(y) + dim_t'(1);
        x_last = x_inc >= lw_reg;
        y_last = y_inc >= lh_reg;
        nw     = ((lw_reg >> 1) == '0) ? dim_t'(1) : (lw_reg >> 1);
        nh     = ((lh_reg >> 1) == '0) ? dim_t'(1) : (lh_reg >> 1);
        stop   = (lw_reg <= dim_t'(1) && lh_reg <= dim_t'(1))
              || (lv_reg == LVW'(MAX_LEVELS - 1))
              || ((dim_t'(x) >> 1) >= nw) || ((dim_t'(y) >> 1) >= nh);

        wr_store = 1'b0;
        wr_left  = 1'b0;
        rd_pair  = 1'b0;
        use_left = 1'b0;
        rd_quad  = 1'b0;
        if (lw_reg == dim_t'(1))
        begin
            if (!y[0]) wr_store = 1'b1;
            else       rd_pair  = 1'b1;
        end
        else if (lh_reg == dim_t'(1))
        begin
            if (!x[0]) wr_left  = 1'b1;
            else       use_left = 1'b1;
        end
        else if (!y[0])
            wr_store = 1'b1;
        else if (!x[0])
            wr_left = 1'b1;
        else
            rd_quad = 1'b1;

        last     = stop || wr_store || wr_left;
        done_now = img_end_reg || (lv_reg == '0 && x_last && y_last);
        go       = !out_valid_reg || result.ready;

        ram_we   = (state_reg == S_LEVEL) && go && !stop && wr_store;
        if (state_reg == S_RD_A)
            ram_addr = off_reg + addr_t'(x_reg);
        else if (rd_quad)
            ram_addr = off_reg + addr_t'(x) - addr_t'(1);
        else if (lw_reg == dim_t'(1))
            ram_addr = off_reg;
        else
            ram_addr = off_reg + addr_t'(x);
    end

    pim_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (v_reg),
        .rdata (ram_rdata)
    );

    assign pixel.ready        = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.level       = out_level_reg;
    assign result.column      = out_col_reg;
    assign result.row         = out_row_reg;
    assign result.value       = out_value_reg;
    assign result.last_in_run = out_last_reg;
    assign result.chain_done  = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_w_reg     <= DIM_RESET;
            cfg_h_reg     <= DIM_RESET;
            out_valid_reg <= 1'b0;
            img_end_reg   <= 1'b0;
            lv_reg        <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
                left_reg[i] <= '0;
            end
        end
        else
        begin
            if (result.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE_WIDTH:  cfg_w_reg <= cfg_data;
                    REG_BASE_HEIGHT: cfg_h_reg <= cfg_data;
                endcase
                for (int i = 0; i < MAX_LEVELS; i++)
                begin
                    col_reg[i] <= '0;
                    row_reg[i] <= '0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pixel.valid)
                    begin
                        v_reg       <= pixel.pixel_index;
                        lv_reg      <= '0;
                        off_reg     <= '0;
                        lw_reg      <= clamp_dim(cfg_w_reg);
                        lh_reg      <= clamp_dim(cfg_h_reg);
                        img_end_reg <= 1'b0;
                        state_reg   <= S_LEVEL;
                    end
                end
                S_LEVEL:
                begin
                    if (go)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= LEVEL_W'(lv_reg);
                        out_col_reg   <= COORD_W'(x);
                        out_row_reg   <= COORD_W'(y);
                        out_value_reg <= v_reg;
                        out_last_reg  <= last;
                        out_done_reg  <= last && done_now;
                        img_end_reg   <= done_now;

                        if (x_last)
                        begin
                            col_reg[lv_reg] <= '0;
                            row_reg[lv_reg] <= y_last ? pos_t'(0) : pos_t'(y_inc);
                        end
                        else
                        begin
                            col_reg[lv_reg] <= pos_t'(x_inc);
                        end

                        if (!stop && wr_left)
                            left_reg[lv_reg] <= v_reg;

                        x_reg    <= x;
                        pair_reg <= rd_pair;

                        if (last)
                        begin
                            state_reg <= S_IDLE;
                            if (done_now)
                            begin
                                for (int i = 0; i < MAX_LEVELS; i++)
                                begin
                                    col_reg[i] <= '0;
                                    row_reg[i] <= '0;
                                end
                            end
                        end
                        else if (use_left)
                        begin
                            v_reg   <= left_reg[lv_reg];
                            off_reg <= off_reg + addr_t'(lw_reg);
                            lw_reg  <= nw;
                            lh_reg  <= nh;
                            lv_reg  <= lv_reg + LVW'(1);
                        end
                        else
                        begin
                            state_reg <= S_RD_A;
                        end
                    end
                end
                S_RD_A:
                begin
                    if (pair_reg)
                    begin
                        v_reg     <= ram_rdata;
                        off_reg   <= off_reg + addr_t'(lw_reg);
                        lw_reg    <= nw;
                        lh_reg    <= nh;
                        lv_reg    <= lv_reg + LVW'(1);
                        state_reg <= S_LEVEL;
                    end
                    else
                    begin
                        a0_reg    <= ram_rdata;
                        state_reg <= S_RD_B;
                    end
                end
                S_RD_B:
                begin
                    v_reg     <= mode4(a0_reg, ram_rdata, left_reg[lv_reg], v_reg);
                    off_reg   <= off_reg + addr_t'(lw_reg);
                    lw_reg    <= nw;
                    lh_reg    <= nh;
                    lv_reg    <= lv_reg + LVW'(1);
                    state_reg <= S_LEVEL;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/pim_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pim_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module pim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
